// ===== rtl/fim_pkg.sv =====
// Shared types and defaults for the feature-to-image index map.
// Used by fim_store, fim_ctrl and feature_to_image_index_map_top; no dependencies.
package fim_pkg;

  localparam int unsigned MAX_IMAGES_DEF  = 1024;
  localparam int unsigned TOTAL_WIDTH_DEF = 32;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } fim_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } fim_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_FETCH,
    S_DONE
  } fim_state_e;

  typedef struct packed {
    fim_op_e     opcode;
    logic [63:0] image_ident;
    logic [15:0] feature_count;
    logic [31:0] global_index;
  } fim_in_t;

  typedef struct packed {
    logic [63:0] found_image;
    logic [31:0] offset_in_image;
    fim_status_e status;
  } fim_out_t;

endpackage

// ===== rtl/feature_to_image_index_map_top.sv =====
// Top level of the feature-to-image index map: sequencer, entry table and
// output register. Depends on fim_pkg, fim_store and fim_ctrl.

// One item is worked at a time. An append goes through the EXEC and DONE states
// on its way to the output register; a lookup in a non-empty table goes through
// EXEC, S search steps in SRCH (S is at most floor(log2(entries)) + 1), then FETCH
// unless it ends past the end, and DONE, with one read of the running total memory per step.
// The next item can be accepted in the cycle after a result enters the output
// register, even while that result still waits there. No clearing pass is
// needed after reset.
module feature_to_image_index_map_top #(
  parameter int unsigned MAX_IMAGES  = fim_pkg::MAX_IMAGES_DEF,
  parameter int unsigned TOTAL_WIDTH = fim_pkg::TOTAL_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fim_pkg::fim_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fim_pkg::fim_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_IMAGES);

  logic                   res_valid, res_take;
  fim_pkg::fim_out_t      res_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr, rd_id_addr, rd_total_addr;
  logic [63:0]            wr_ident, rd_ident;
  logic [TOTAL_WIDTH-1:0] wr_total, rd_total;
  logic                   out_valid_q;
  fim_pkg::fim_out_t      out_data_q;

  fim_ctrl #(
    .MAX_IMAGES  (MAX_IMAGES),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_data_i       (in_data_i),
    .in_stall_o      (in_stall_o),
    .res_valid_o     (res_valid),
    .res_data_o      (res_data),
    .res_take_i      (res_take),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_ident_o      (wr_ident),
    .wr_total_o      (wr_total),
    .rd_id_addr_o    (rd_id_addr),
    .rd_total_addr_o (rd_total_addr),
    .rd_ident_i      (rd_ident),
    .rd_total_i      (rd_total)
  );

  fim_store #(
    .MAX_IMAGES  (MAX_IMAGES),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_store (
    .clk_i           (clk_i),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .wr_ident_i      (wr_ident),
    .wr_total_i      (wr_total),
    .rd_id_addr_i    (rd_id_addr),
    .rd_total_addr_i (rd_total_addr),
    .rd_ident_o      (rd_ident),
    .rd_total_o      (rd_total)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/fim_store.sv =====
// Entry table: image id memory and running total memory, one write and one
// registered read port each. Depends on fim_pkg for parameter defaults.
module fim_store #(
  parameter int unsigned MAX_IMAGES  = fim_pkg::MAX_IMAGES_DEF,
  parameter int unsigned TOTAL_WIDTH = fim_pkg::TOTAL_WIDTH_DEF,
  localparam int unsigned IDX_W      = $clog2(MAX_IMAGES)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IDX_W-1:0]       wr_addr_i,
  input  logic [63:0]            wr_ident_i,
  input  logic [TOTAL_WIDTH-1:0] wr_total_i,
  input  logic [IDX_W-1:0]       rd_id_addr_i,
  input  logic [IDX_W-1:0]       rd_total_addr_i,
  output logic [63:0]            rd_ident_o,
  output logic [TOTAL_WIDTH-1:0] rd_total_o
);

  logic [63:0]            id_mem    [MAX_IMAGES];
  logic [TOTAL_WIDTH-1:0] total_mem [MAX_IMAGES];
  logic [63:0]            rd_ident_q;
  logic [TOTAL_WIDTH-1:0] rd_total_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_mem[wr_addr_i] <= wr_ident_i;
    end
    rd_ident_q <= id_mem[rd_id_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      total_mem[wr_addr_i] <= wr_total_i;
    end
    rd_total_q <= total_mem[rd_total_addr_i];
  end

  assign rd_ident_o = rd_ident_q;
  assign rd_total_o = rd_total_q;

endmodule

// ===== rtl/fim_ctrl.sv =====
// Sequencer: appends entries and runs the upper-bound binary search against
// the entry table. Depends on fim_pkg; drives the ports of fim_store.
module fim_ctrl #(
  parameter int unsigned MAX_IMAGES  = fim_pkg::MAX_IMAGES_DEF,
  parameter int unsigned TOTAL_WIDTH = fim_pkg::TOTAL_WIDTH_DEF,
  localparam int unsigned IDX_W      = $clog2(MAX_IMAGES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  fim_pkg::fim_in_t       in_data_i,
  output logic                   in_stall_o,
  output logic                   res_valid_o,
  output fim_pkg::fim_out_t      res_data_o,
  input  logic                   res_take_i,
  output logic                   wr_en_o,
  output logic [IDX_W-1:0]       wr_addr_o,
  output logic [63:0]            wr_ident_o,
  output logic [TOTAL_WIDTH-1:0] wr_total_o,
  output logic [IDX_W-1:0]       rd_id_addr_o,
  output logic [IDX_W-1:0]       rd_total_addr_o,
  input  logic [63:0]            rd_ident_i,
  input  logic [TOTAL_WIDTH-1:0] rd_total_i
);

  localparam int unsigned CNT_W = $clog2(MAX_IMAGES + 1);
  localparam int unsigned SUM_W = TOTAL_WIDTH + 1;
  localparam int unsigned CMP_W = (TOTAL_WIDTH > 32) ? TOTAL_WIDTH : 32;

  fim_pkg::fim_state_e    state_q, state_d;
  fim_pkg::fim_in_t       item_q, item_d;
  fim_pkg::fim_out_t      res_q, res_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;
  logic [CNT_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       mid_init, lo_n, hi_n, mid_n, lo_prev;
  logic [CMP_W-1:0]       base_ext;
  logic [31:0]            base32;
  logic                   idx_lt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fim_pkg::S_IDLE;
      count_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  assign sum      = {1'b0, total_q} + SUM_W'(item_q.feature_count);
  assign mid_init = count_q >> 1;
  assign idx_lt   = CMP_W'(item_q.global_index) < CMP_W'(rd_total_i);
  assign lo_n     = idx_lt ? lo_q : mid_q + CNT_W'(1);
  assign hi_n     = idx_lt ? mid_q : hi_q;
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);
  assign lo_prev  = lo_n - CNT_W'(1);
  assign base_ext = CMP_W'(rd_total_i);
  assign base32   = (lo_q == '0) ? 32'd0 : base_ext[31:0];

  assign wr_addr_o  = count_q[IDX_W-1:0];
  assign wr_ident_o = item_q.image_ident;
  assign wr_total_o = sum[TOTAL_WIDTH-1:0];
  assign res_data_o = res_q;

  always_comb begin
    state_d         = state_q;
    item_d          = item_q;
    res_d           = res_q;
    count_d         = count_q;
    total_d         = total_q;
    lo_d            = lo_q;
    hi_d            = hi_q;
    mid_d           = mid_q;
    in_stall_o      = 1'b1;
    res_valid_o     = 1'b0;
    wr_en_o         = 1'b0;
    rd_total_addr_o = mid_q[IDX_W-1:0];
    rd_id_addr_o    = lo_q[IDX_W-1:0];
    case (state_q)
      fim_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = fim_pkg::S_EXEC;
        end
      end
      fim_pkg::S_EXEC: begin
        res_d   = '{found_image: '0, offset_in_image: '0, status: fim_pkg::ST_OK};
        state_d = fim_pkg::S_DONE;
        if (item_q.opcode == fim_pkg::OP_APPEND) begin
          if (count_q == CNT_W'(MAX_IMAGES)) begin
            res_d.status = fim_pkg::ST_FULL;
          end else if (sum[TOTAL_WIDTH]) begin
            res_d.status = fim_pkg::ST_OVERFLOW;
          end else begin
            wr_en_o = 1'b1;
            count_d = count_q + CNT_W'(1);
            total_d = sum[TOTAL_WIDTH-1:0];
          end
        end else if (count_q == '0) begin
          res_d.status = fim_pkg::ST_PAST_END;
        end else begin
          lo_d            = '0;
          hi_d            = count_q;
          mid_d           = mid_init;
          rd_total_addr_o = mid_init[IDX_W-1:0];
          state_d         = fim_pkg::S_SRCH;
        end
      end
      fim_pkg::S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d           = mid_n;
          rd_total_addr_o = mid_n[IDX_W-1:0];
        end else if (lo_n >= count_q) begin
          res_d   = '{found_image: '0, offset_in_image: '0,
                      status: fim_pkg::ST_PAST_END};
          state_d = fim_pkg::S_DONE;
        end else begin
          rd_total_addr_o = lo_prev[IDX_W-1:0];
          rd_id_addr_o    = lo_n[IDX_W-1:0];
          state_d         = fim_pkg::S_FETCH;
        end
      end
      fim_pkg::S_FETCH: begin
        res_d   = '{found_image: rd_ident_i,
                    offset_in_image: item_q.global_index - base32,
                    status: fim_pkg::ST_OK};
        state_d = fim_pkg::S_DONE;
      end
      fim_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = fim_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fim_pkg::S_IDLE;
      end
    endcase
  end

endmodule
